@@ rtl/core/sapd_pkg.sv @@
// ----------------------------------------------------------------------------
// sapd_pkg
// shared types, codes and tables of the stereo audio frame decoder
// ----------------------------------------------------------------------------
package sapd_pkg;

  localparam logic [2:0] FMT_PCM16 = 3'd2;
  localparam logic [2:0] FMT_PCM8  = 3'd3;
  localparam logic [2:0] FMT_ADPCM = 3'd4;
  localparam logic [2:0] FMT_DUAL  = 3'd5;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_MUSIC  = 2'd1;
  localparam logic [1:0] REG_EFFECT = 2'd2;
  localparam logic [1:0] REG_STEREO = 2'd3;

  localparam int BLOCK_DEPTH = 36;
  localparam logic [15:0] MONO_GAIN = 16'hBFFD;

  // decode job handed from the collector to the decode engine
  typedef struct packed {
    logic [2:0] fmt;
  } job_t;

  function automatic logic signed [13:0] coef1(input logic [3:0] i);
    case (i)
      4'd0: coef1 = 14'sd0;      4'd1: coef1 = 14'sh0800;
      4'd2: coef1 = 14'sd0;      4'd3: coef1 = 14'sh0400;
      4'd4: coef1 = 14'sh1000;   4'd5: coef1 = 14'sh0E00;
      4'd6: coef1 = 14'sh0C00;   4'd7: coef1 = 14'sh1200;
      4'd8: coef1 = 14'sh1068;   4'd9: coef1 = 14'sh12C0;
      4'd10: coef1 = 14'sh1400;  4'd11: coef1 = 14'sh0800;
      4'd12: coef1 = 14'sh0400;  4'd13: coef1 = -14'sh0400;
      4'd14: coef1 = -14'sh0400; default: coef1 = -14'sh0800;
    endcase
  endfunction

  function automatic logic signed [13:0] coef2(input logic [3:0] i);
    case (i)
      4'd2: coef2 = 14'sh0800;   4'd3: coef2 = 14'sh0400;
      4'd4: coef2 = -14'sh0800;  4'd5: coef2 = -14'sh0600;
      4'd6: coef2 = -14'sh0400;  4'd7: coef2 = -14'sh0A00;
      4'd8: coef2 = -14'sh08C8;  4'd9: coef2 = -14'sh08FC;
      4'd10: coef2 = -14'sh0C00; 4'd11: coef2 = -14'sh0800;
      4'd12: coef2 = -14'sh0400; 4'd13: coef2 = 14'sh0400;
      default: coef2 = 14'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) sat16 = 16'sh7fff;
    else if (v < -36'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

@@ rtl/core/sapd_front.sv @@
// ----------------------------------------------------------------------------
// sapd_front
// collects stream bytes into a frame buffer and posts a decode job when a frame is complete
// ----------------------------------------------------------------------------
module sapd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        audio_format,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              job_valid,
  output sapd_pkg::job_t    job,
  input  logic              job_done,
  input  logic [5:0]        rd_addr,
  output logic [7:0]        rd_data
);
  import sapd_pkg::*;

  logic [7:0] mem [BLOCK_DEPTH];
  logic [5:0] byte_count;
  logic       busy;
  logic [5:0] size;
  logic       fmt_ok;

  always_comb begin
    fmt_ok = 1'b1;
    unique case (audio_format)
      FMT_PCM16: size = 6'd4;
      FMT_PCM8:  size = 6'd2;
      FMT_ADPCM: size = 6'd18;
      FMT_DUAL:  size = 6'd36;
      default: begin
        size = 6'd36;
        fmt_ok = 1'b0;
      end
    endcase
  end

  assign in_ready  = !busy;
  assign job_valid = busy;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && fmt_ok && byte_count < 6'(BLOCK_DEPTH))
      mem[byte_count] <= in_byte;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      busy <= 1'b0;
      job.fmt <= FMT_ADPCM;
    end else begin
      if (job_done) busy <= 1'b0;
      if (in_valid && in_ready && fmt_ok) begin
        if (byte_count + 6'd1 >= size) begin
          byte_count <= '0;
          busy <= 1'b1;
          job.fmt <= audio_format;
        end else begin
          byte_count <= byte_count + 6'd1;
        end
      end
    end
  end

endmodule

@@ rtl/core/sapd_back.sv @@
// ----------------------------------------------------------------------------
// sapd_back
// decodes one frame job: pcm paths or adpcm predictor, level scaling and mix
// ----------------------------------------------------------------------------
module sapd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       music_level,
  input  logic [15:0]       effects_level,
  input  logic              stereo_enable,
  input  logic              job_valid,
  input  sapd_pkg::job_t    job,
  output logic              job_done,
  output logic [5:0]        rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_left,
  output logic [15:0]       out_right,
  output logic              out_last
);
  import sapd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PCM  = 4'd1;
  localparam logic [3:0] S_HDR  = 4'd2;
  localparam logic [3:0] S_NIB  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_SCL  = 4'd6;
  localparam logic [3:0] S_MIX  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;

  logic [3:0] state;
  logic [5:0] raddr;
  logic       rwait;
  logic [2:0] pcm_idx;
  logic [7:0] pb [4];
  logic       dual, strm, chn;
  logic [3:0] k;
  logic [3:0] scale, cidx;
  logic [7:0] packed_b;
  logic signed [15:0] hp [4];
  logic signed [15:0] he [4];
  logic signed [15:0] smp [2][2][16];
  logic signed [15:0] rdl, rdr;
  logic signed [29:0] p1, p2;
  logic signed [16:0] sl, sr;
  logic signed [33:0] ml_p, mr_p;
  logic signed [17:0] accl, accr;
  logic signed [35:0] mxl, mxr;
  logic [3:0] oi;
  logic       ost;

  logic signed [15:0] lat, prv;
  logic [3:0] nib;
  logic signed [35:0] pred, sval;

  assign rd_addr = raddr;
  assign lat = strm ? he[{chn, 1'b0}] : hp[{chn, 1'b0}];
  assign prv = strm ? he[{chn, 1'b1}] : hp[{chn, 1'b1}];
  assign nib = k[0] ? packed_b[3:0] : packed_b[7:4];
  assign pred = (36'(p1) + 36'(p2)) >>> 11;
  assign sval = (36'(signed'(nib)) <<< scale) + pred;

  // registered read of the decoded sample store
  always_ff @(posedge clk) begin
    rdl <= smp[ost][0][oi];
    rdr <= smp[ost][1][oi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_done <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hp[i] <= '0;
        he[i] <= '0;
      end
      raddr <= '0;
      rwait <= 1'b0;
    end else begin
      job_done <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid && !job_done) begin
            dual <= job.fmt == FMT_DUAL;
            raddr <= '0;
            rwait <= 1'b1;
            pcm_idx <= '0;
            strm <= 1'b0;
            chn <= 1'b0;
            state <= (job.fmt == FMT_PCM16 || job.fmt == FMT_PCM8) ? S_PCM : S_HDR;
          end
        end
        S_PCM: begin
          if (rwait) rwait <= 1'b0;
          else begin
            pb[pcm_idx[1:0]] <= rd_data;
            if (pcm_idx == 3'd3) begin
              state <= S_SCL;
              rwait <= 1'b1;
              oi <= 4'd15;
              ost <= 1'b0;
            end else begin
              pcm_idx <= pcm_idx + 3'd1;
              raddr <= raddr + 6'd1;
              rwait <= 1'b1;
            end
          end
        end
        S_HDR: begin
          if (rwait) rwait <= 1'b0;
          else begin
            scale <= rd_data[7:4];
            cidx <= rd_data[3:0];
            k <= '0;
            raddr <= raddr + 6'd1;
            rwait <= 1'b1;
            state <= S_NIB;
          end
        end
        S_NIB: begin
          if (rwait) rwait <= 1'b0;
          else begin
            if (!k[0]) packed_b <= rd_data;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          p1 <= coef1(cidx) * lat;
          p2 <= coef2(cidx) * prv;
          state <= S_SUM;
        end
        S_SUM: begin
          smp[strm][chn][k] <= sat16(sval);
          if (strm) begin
            he[{chn, 1'b1}] <= lat;
            he[{chn, 1'b0}] <= sat16(sval);
          end else begin
            hp[{chn, 1'b1}] <= lat;
            hp[{chn, 1'b0}] <= sat16(sval);
          end
          if (k == 4'd15) begin
            raddr <= raddr + 6'd1;
            rwait <= 1'b1;
            if (!chn) begin
              chn <= 1'b1;
              state <= S_HDR;
            end else if (dual && !strm) begin
              strm <= 1'b1;
              chn <= 1'b0;
              state <= S_HDR;
            end else begin
              oi <= '0;
              ost <= 1'b0;
              state <= S_SCL;
            end
          end else begin
            k <= k + 4'd1;
            if (k[0]) begin
              raddr <= raddr + 6'd1;
              rwait <= 1'b1;
            end
            state <= S_NIB;
          end
        end
        S_SCL: begin
          if (rwait) rwait <= 1'b0;
          else begin
            ml_p <= sl * signed'({1'b0, ost ? effects_level : music_level});
            mr_p <= sr * signed'({1'b0, ost ? effects_level : music_level});
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (!ost) begin
            accl <= 18'(ml_p >>> 15);
            accr <= 18'(mr_p >>> 15);
          end else begin
            accl <= accl + 18'(ml_p >>> 15);
            accr <= accr + 18'(mr_p >>> 15);
          end
          if (dual && !ost && state == S_ACC && pcm_idx != 3'd3) begin
            ost <= 1'b1;
            rwait <= 1'b1;
            state <= S_SCL;
          end else begin
            state <= S_MIX;
          end
        end
        S_MIX: begin
          mxl <= accl * signed'({1'b0, MONO_GAIN});
          mxr <= accr * signed'({1'b0, MONO_GAIN});
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (stereo_enable) begin
              out_left <= sat16(36'(accl));
              out_right <= sat16(36'(accl) - 36'(accl) + 36'(accr));
            end else begin
              out_left <= sat16(((mxl < 0) ? -((-mxl) >>> 16) : (mxl >>> 16))
                + ((mxr < 0) ? -((-mxr) >>> 16) : (mxr >>> 16)));
              out_right <= sat16(((mxl < 0) ? -((-mxl) >>> 16) : (mxl >>> 16))
                + ((mxr < 0) ? -((-mxr) >>> 16) : (mxr >>> 16)));
            end
            out_valid <= 1'b1;
            out_last <= (pcm_idx == 3'd3) || (oi == 4'd15);
            if (pcm_idx == 3'd3 || oi == 4'd15) begin
              job_done <= 1'b1;
              state <= S_IDLE;
            end else begin
              oi <= oi + 4'd1;
              ost <= 1'b0;
              rwait <= 1'b1;
              state <= S_SCL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stream sample feeding the level multiplier
  always_comb begin
    if (pcm_idx == 3'd3) begin
      if (job.fmt == FMT_PCM16) begin
        sl = 17'(signed'({pb[0], pb[1]}));
        sr = 17'(signed'({pb[2], pb[3]}));
      end else begin
        sl = 17'(signed'({1'b0, pb[0]}) - 17'sd128) <<< 8;
        sr = 17'(signed'({1'b0, pb[1]}) - 17'sd128) <<< 8;
      end
    end else begin
      sl = 17'(rdl);
      sr = 17'(rdr);
    end
  end

endmodule

@@ rtl/core/stereo_adpcm_pcm_audio_decoder.sv @@
// ----------------------------------------------------------------------------
// stereo_adpcm_pcm_audio_decoder
// byte-stream audio decoder: pcm16, pcm8 and single or dual 4-bit adpcm blocks
// throughput: 1 byte per cycle while collecting; the predictor decodes each
// nibble through read, multiply and sum steps, one channel after the other;
// each output frame is scaled, accumulated, mixed and posted, with the effects
// stream added for dual; bytes stall while a decode job is pending, until the
// decode engine reports it done after the last sample of the frame is posted
// reset: synchronous, clears counters, predictor history and registers
// ----------------------------------------------------------------------------
module stereo_adpcm_pcm_audio_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // right_sample, left_sample
  output logic        m_axis_tlast    // last_of_run
);
  import sapd_pkg::*;

  logic [2:0]  audio_format;
  logic [15:0] music_level, effects_level;
  logic        stereo_enable;
  logic        job_valid, job_done;
  job_t        job;
  logic [5:0]  rd_addr;
  logic [7:0]  rd_data;
  logic [15:0] ol, orr;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_format <= FMT_ADPCM;
      music_level <= 16'd32767;
      effects_level <= 16'd32767;
      stereo_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT: audio_format <= cfg_data[2:0];
        REG_MUSIC:  music_level <= cfg_data;
        REG_EFFECT: effects_level <= cfg_data;
        REG_STEREO: stereo_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sapd_front u_front (
    .clk, .rst, .audio_format,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
    .job_valid, .job, .job_done, .rd_addr, .rd_data
  );

  sapd_back u_back (
    .clk, .rst, .music_level, .effects_level, .stereo_enable,
    .job_valid, .job, .job_done, .rd_addr, .rd_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_left(ol), .out_right(orr), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {orr, ol};

endmodule
